### src/tlsf_pkg.sv
package tlsf_pkg;

  localparam int unsigned SIZE_W          = 30;
  localparam int unsigned CLASS_W         = 5;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned MIN_BLOCK_BYTES = 12;

  localparam int unsigned SECOND_LEVEL_LOG2_DEF = 5;
  localparam int unsigned MAX_SIZE_LOG2_DEF     = 30;
  localparam int unsigned ALIGN_LOG2_DEF        = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } tlsf_cmd_e;

  // mapped command handed from the mapper to the bitmap store
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               emptied;
    logic               class_ok;
    logic [CLASS_W-1:0] fl;
    logic [CLASS_W-1:0] sl;
  } tlsf_req_t;

  // class answer from the bitmap store
  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] fl;
    logic [CLASS_W-1:0] sl;
  } tlsf_hit_t;

endpackage

### src/tlsf_mapper.sv
module tlsf_mapper #(
  parameter int unsigned SECOND_LEVEL_LOG2 = tlsf_pkg::SECOND_LEVEL_LOG2_DEF,
  parameter int unsigned MAX_SIZE_LOG2     = tlsf_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned ALIGN_LOG2        = tlsf_pkg::ALIGN_LOG2_DEF
) (
  input  logic [tlsf_pkg::CMD_W-1:0]  cmd_i,
  input  logic [tlsf_pkg::SIZE_W-1:0] size_i,
  input  logic                        emptied_i,
  output tlsf_pkg::tlsf_req_t         req_o,
  output logic [tlsf_pkg::SIZE_W-1:0] adj_o
);
  import tlsf_pkg::*;

  localparam int unsigned FlShift    = SECOND_LEVEL_LOG2 + ALIGN_LOG2;
  localparam int unsigned FlCount    = MAX_SIZE_LOG2 - FlShift + 1;
  localparam int unsigned SmallLimit = 1 << FlShift;
  localparam int unsigned AlignLow   = (1 << ALIGN_LOG2) - 1;

  function automatic logic [4:0] msb_idx(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic [SIZE_W:0] sum_a;
  logic [SIZE_W:0] aligned;
  logic [SIZE_W:0] adj_w;
  logic            a_ok;
  logic            big;
  logic            is_search;
  logic [4:0]      t_a;
  logic [4:0]      t_m;
  logic [31:0]     rounded;
  logic [31:0]     map_in;
  logic [31:0]     sl_full;
  logic [5:0]      fl6;

  assign is_search = (cmd_i == CMD_SEARCH);
  assign big       = ((size_i >> MAX_SIZE_LOG2) != '0);
  assign sum_a     = {1'b0, size_i} + (SIZE_W+1)'(AlignLow);
  assign aligned   = sum_a & ~((SIZE_W+1)'(AlignLow));
  assign a_ok      = (size_i != '0) && ((aligned >> MAX_SIZE_LOG2) == '0);
  assign adj_w     = (aligned < (SIZE_W+1)'(MIN_BLOCK_BYTES)) ?
                     (SIZE_W+1)'(MIN_BLOCK_BYTES) : aligned;

  always_comb begin
    t_a = msb_idx(32'(adj_w));
    if (32'(adj_w) >= 32'(SmallLimit)) begin
      rounded = 32'(adj_w) + ((32'd1 << (t_a - 5'(SECOND_LEVEL_LOG2))) - 32'd1);
    end else begin
      rounded = 32'(adj_w);
    end
    map_in = is_search ? rounded : 32'(size_i);
    t_m    = msb_idx(map_in);
    if (map_in < 32'(SmallLimit)) begin
      fl6     = '0;
      sl_full = map_in >> ALIGN_LOG2;
    end else begin
      fl6     = 6'(t_m) - 6'(FlShift - 1);
      sl_full = (map_in >> (t_m - 5'(SECOND_LEVEL_LOG2))) ^ (32'd1 << SECOND_LEVEL_LOG2);
    end
  end

  always_comb begin
    req_o.cmd     = cmd_i;
    req_o.emptied = emptied_i;
    req_o.fl      = fl6[CLASS_W-1:0];
    req_o.sl      = sl_full[CLASS_W-1:0];
    case (cmd_i)
      CMD_SEARCH:             req_o.class_ok = a_ok && (fl6 < 6'(FlCount));
      CMD_INSERT, CMD_REMOVE: req_o.class_ok = !big;
      default:                req_o.class_ok = 1'b0;
    endcase
    adj_o = (is_search && a_ok) ? adj_w[SIZE_W-1:0] : '0;
  end

endmodule

### src/tlsf_bitmap.sv
module tlsf_bitmap #(
  parameter int unsigned SECOND_LEVEL_LOG2 = tlsf_pkg::SECOND_LEVEL_LOG2_DEF,
  parameter int unsigned MAX_SIZE_LOG2     = tlsf_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned ALIGN_LOG2        = tlsf_pkg::ALIGN_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tlsf_pkg::tlsf_req_t req_i,
  output tlsf_pkg::tlsf_hit_t hit_o
);
  import tlsf_pkg::*;

  localparam int unsigned FlShift = SECOND_LEVEL_LOG2 + ALIGN_LOG2;
  localparam int unsigned FlCount = MAX_SIZE_LOG2 - FlShift + 1;
  localparam int unsigned SlCount = 1 << SECOND_LEVEL_LOG2;

  function automatic logic [4:0] lsb_idx(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic [FlCount-1:0] fl_map_q, fl_map_d;
  logic [SlCount-1:0] sl_map_q [FlCount];
  logic [SlCount-1:0] sl_map_d [FlCount];

  logic [SlCount-1:0] sl_mask;
  logic [SlCount-1:0] sl_bit;
  logic [SlCount-1:0] cand  [FlCount];
  logic [FlCount-1:0] lane_nz;
  logic [4:0]         lane_sl [FlCount];
  logic [FlCount-1:0] is_f;
  logic [FlCount-1:0] above_f;
  logic               do_ins;
  logic               do_rem;
  logic               sel_any;
  logic [4:0]         sel_fl;
  logic [4:0]         sel_sl;

  assign sl_mask = {SlCount{1'b1}} << req_i.sl;
  assign sl_bit  = {{(SlCount-1){1'b0}}, 1'b1} << req_i.sl;
  assign do_ins  = fire_i && req_i.class_ok && (req_i.cmd == CMD_INSERT);
  assign do_rem  = fire_i && req_i.class_ok && (req_i.cmd == CMD_REMOVE) && req_i.emptied;

  // per-row search lanes and row updates
  always_comb begin
    for (int i = 0; i < FlCount; i++) begin
      is_f[i]    = (req_i.fl == 5'(i));
      above_f[i] = (5'(i) > req_i.fl);
      if (is_f[i]) begin
        cand[i] = sl_map_q[i] & sl_mask;
      end else if (above_f[i] && fl_map_q[i]) begin
        cand[i] = sl_map_q[i];
      end else begin
        cand[i] = '0;
      end
      lane_nz[i] = (cand[i] != '0);
      lane_sl[i] = lsb_idx(32'(cand[i]));

      sl_map_d[i] = sl_map_q[i];
      fl_map_d[i] = fl_map_q[i];
      if (do_ins && is_f[i]) begin
        sl_map_d[i] = sl_map_q[i] | sl_bit;
        fl_map_d[i] = 1'b1;
      end else if (do_rem && is_f[i]) begin
        sl_map_d[i] = sl_map_q[i] & ~sl_bit;
        if ((sl_map_q[i] & ~sl_bit) == '0) fl_map_d[i] = 1'b0;
      end
    end
  end

  always_comb begin
    sel_any = 1'b0;
    sel_fl  = '0;
    sel_sl  = '0;
    for (int i = FlCount - 1; i >= 0; i--) begin
      if (lane_nz[i]) begin
        sel_any = 1'b1;
        sel_fl  = 5'(i);
        sel_sl  = lane_sl[i];
      end
    end
  end

  always_comb begin
    hit_o = '0;
    case (req_i.cmd)
      CMD_SEARCH: begin
        if (req_i.class_ok && sel_any) begin
          hit_o.found = 1'b1;
          hit_o.fl    = sel_fl;
          hit_o.sl    = sel_sl;
        end
      end
      CMD_INSERT, CMD_REMOVE: begin
        if (req_i.class_ok) begin
          hit_o.found = 1'b1;
          hit_o.fl    = req_i.fl;
          hit_o.sl    = req_i.sl;
        end
      end
      default: hit_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_map_q <= '0;
      for (int i = 0; i < FlCount; i++) begin
        sl_map_q[i] <= '0;
      end
    end else begin
      fl_map_q <= fl_map_d;
      for (int i = 0; i < FlCount; i++) begin
        sl_map_q[i] <= sl_map_d[i];
      end
    end
  end

endmodule

### src/tlsf_class_bitmap_engine_top.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o    command_i, size_bytes_i, class_emptied_i
// out      output     out_valid_o/out_stall_i  found_o, first_level_o, second_level_o,
//                                              adjusted_size_o
//
// one transaction per cycle while out_stall_i is low; an accepted command goes to the
// input register, then through class mapping, bitmap search and update into the result register
// bitmaps update as the result register loads, so the next command sees them
// reset clears both bitmap levels and all valid flags at once
// a stalled result holds the input register, which then stalls the input
module tlsf_class_bitmap_engine_top #(
  parameter int unsigned SECOND_LEVEL_LOG2 = tlsf_pkg::SECOND_LEVEL_LOG2_DEF,
  parameter int unsigned MAX_SIZE_LOG2     = tlsf_pkg::MAX_SIZE_LOG2_DEF,
  parameter int unsigned ALIGN_LOG2        = tlsf_pkg::ALIGN_LOG2_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlsf_pkg::CMD_W-1:0]     command_i,
  input  logic [tlsf_pkg::SIZE_W-1:0]    size_bytes_i,
  input  logic                           class_emptied_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [tlsf_pkg::CLASS_W-1:0]   first_level_o,
  output logic [tlsf_pkg::CLASS_W-1:0]   second_level_o,
  output logic [tlsf_pkg::SIZE_W-1:0]    adjusted_size_o
);
  import tlsf_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic              emptied_q;
  logic              out_valid_q, out_valid_d;
  tlsf_hit_t         hit_q;
  logic [SIZE_W-1:0] adj_q;

  logic              accept;
  logic              advance;
  tlsf_req_t         req;
  tlsf_hit_t         hit;
  logic [SIZE_W-1:0] adj;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  tlsf_mapper #(
    .SECOND_LEVEL_LOG2(SECOND_LEVEL_LOG2),
    .MAX_SIZE_LOG2    (MAX_SIZE_LOG2),
    .ALIGN_LOG2       (ALIGN_LOG2)
  ) u_mapper (
    .cmd_i    (cmd_q),
    .size_i   (size_q),
    .emptied_i(emptied_q),
    .req_o    (req),
    .adj_o    (adj)
  );

  tlsf_bitmap #(
    .SECOND_LEVEL_LOG2(SECOND_LEVEL_LOG2),
    .MAX_SIZE_LOG2    (MAX_SIZE_LOG2),
    .ALIGN_LOG2       (ALIGN_LOG2)
  ) u_bitmap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .req_i (req),
    .hit_o (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= command_i;
      size_q    <= size_bytes_i;
      emptied_q <= class_emptied_i;
    end
    if (advance) begin
      hit_q <= hit;
      adj_q <= adj;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = hit_q.found;
  assign first_level_o   = hit_q.fl;
  assign second_level_o  = hit_q.sl;
  assign adjusted_size_o = adj_q;

endmodule
